[rtl/at2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at2d_pkg
// widths, constants, the arctangent table and the pipeline item type
// ----------------------------------------------------------------------------
package at2d_pkg;

    localparam int COMP_W     = 16;   // width of each direction component
    localparam int OUT_W      = 16;   // width of the angle result
    localparam int ITERATIONS = 16;   // requested micro-rotations
    localparam int TABLE_LEN  = 24;   // entries in the arctangent table
    localparam int STAGES     = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
    localparam int STAGE_W    = $clog2(TABLE_LEN);
    localparam int PRESCALE   = 24;   // components are scaled by 2^PRESCALE
    localparam int GUARD      = 3;    // headroom for negation and cordic gain
    localparam int X_W        = GUARD + COMP_W + PRESCALE;
    localparam int Z_W        = 25;   // angle accumulator, 1/65536 degree
    localparam int RND_SHIFT  = 9;    // 1/65536 -> 1/128 degree
    localparam int R_W        = Z_W + 1 - RND_SHIFT;
    localparam int A_W        = 17;   // base angle and rounded angle, 1/128 degree

    localparam logic signed [A_W-1:0] HALF_TURN    = A_W'(23040);
    localparam logic signed [A_W-1:0] QUARTER_TURN = A_W'(11520);
    localparam logic signed [Z_W:0]   RND_HALF     = (Z_W + 1)'(256);

    // round(atan(2^-i) * 180/pi * 65536)
    localparam int ATAN_Q16 [TABLE_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // one item as it moves down the chain
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic signed [A_W-1:0] base;  // quadrant offset or exact axis angle
        logic                  rot;   // cordic result is added to base
    } vec_t;

    function automatic logic signed [Z_W-1:0] atan_entry(logic [STAGE_W-1:0] idx);
        return Z_W'(ATAN_Q16[idx]);
    endfunction

    function automatic logic [STAGE_W-1:0] stage_code(int i);
        return i[STAGE_W-1:0];
    endfunction

endpackage

[rtl/atan2_degrees.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_degrees
// four-quadrant angle of a signed 2-D direction, in 1/128 degree
// ----------------------------------------------------------------------------
// Takes one (dir_x, dir_y) item per unstalled cycle; returns its angle as atan2
// would, signed, in 1/128 degree from -23040 (-180 deg) to +23040 (+180 deg).
// Axis directions get exact angles: x=0 gives +/-90 by the sign of y, y=0 with
// negative x gives +180, and the zero vector gives 0. Everything else goes
// through a 16-stage cordic vectoring chain; vectors with negative x are
// turned by half a circle first and +/-180 is added back by the sign of y.
// The design is a row of register cells: an entry cell, one cell per cordic
// micro-rotation, and an exit cell that rounds and saturates. Sustained rate
// is one item per clock while out_ready stays high; an accepted item passes
// through the entry cell register, each cordic cell register and the exit
// cell's output register in turn before its result shows on the output.
// Each cell holds its item until the next cell takes it, so bubbles in the
// chain keep accepting items while a finished result waits at the output.
// ----------------------------------------------------------------------------
module atan2_degrees (
    input  logic                              clk,
    input  logic                              rst_n,
    // input item
    input  logic signed [at2d_pkg::COMP_W-1:0] dir_x,
    input  logic signed [at2d_pkg::COMP_W-1:0] dir_y,
    input  logic                              in_valid,
    output logic                              in_ready,
    // result item
    output logic signed [at2d_pkg::OUT_W-1:0] angle,
    output logic                              out_valid,
    input  logic                              out_ready
);

    // chain links: link k feeds cordic cell k, link STAGES feeds the exit cell
    at2d_pkg::vec_t vec_link   [at2d_pkg::STAGES+1];
    logic           valid_link [at2d_pkg::STAGES+1];
    logic           ready_link [at2d_pkg::STAGES+1];

    // entry cell: axis cases and half-plane folding
    at2d_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_vec   (vec_link[0]),
        .out_valid (valid_link[0]),
        .out_ready (ready_link[0])
    );

    // cordic micro-rotations, shift and table entry fixed by position
    genvar gi;
    generate
        for (gi = 0; gi < at2d_pkg::STAGES; gi++)
        begin : g_cell
            logic [at2d_pkg::STAGE_W-1:0] stage_idx;

            assign stage_idx = at2d_pkg::stage_code(gi);

            at2d_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .stage     (stage_idx),
                .in_vec    (vec_link[gi]),
                .in_valid  (valid_link[gi]),
                .in_ready  (ready_link[gi]),
                .out_vec   (vec_link[gi+1]),
                .out_valid (valid_link[gi+1]),
                .out_ready (ready_link[gi+1])
            );
        end
    endgenerate

    // exit cell: rounding, quadrant offset, saturation, output register
    at2d_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vec    (vec_link[at2d_pkg::STAGES]),
        .in_valid  (valid_link[at2d_pkg::STAGES]),
        .in_ready  (ready_link[at2d_pkg::STAGES]),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

[rtl/at2d_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at2d_prep
// entry cell: sorts out axis cases and folds the vector into the right half
// ----------------------------------------------------------------------------
module at2d_prep (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [at2d_pkg::COMP_W-1:0] dir_x,
    input  logic signed [at2d_pkg::COMP_W-1:0] dir_y,
    input  logic                              in_valid,
    output logic                              in_ready,
    output at2d_pkg::vec_t                    out_vec,
    output logic                              out_valid,
    input  logic                              out_ready
);

    at2d_pkg::vec_t        vec_reg;
    at2d_pkg::vec_t        vec_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic signed [at2d_pkg::X_W-1:0] xs;
    logic signed [at2d_pkg::X_W-1:0] ys;
    logic                  x_zero;
    logic                  y_zero;
    logic                  x_neg;
    logic                  y_neg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_vec   = vec_reg;
    assign out_valid = valid_reg;

    always_comb
    begin
        xs     = {{at2d_pkg::GUARD{dir_x[at2d_pkg::COMP_W-1]}}, dir_x,
                  {at2d_pkg::PRESCALE{1'b0}}};
        ys     = {{at2d_pkg::GUARD{dir_y[at2d_pkg::COMP_W-1]}}, dir_y,
                  {at2d_pkg::PRESCALE{1'b0}}};
        x_zero = (dir_x == '0);
        y_zero = (dir_y == '0);
        x_neg  = dir_x[at2d_pkg::COMP_W-1];
        y_neg  = dir_y[at2d_pkg::COMP_W-1];

        vec_next.x    = xs;
        vec_next.y    = ys;
        vec_next.z    = '0;
        vec_next.base = '0;
        vec_next.rot  = 1'b0;

        if (x_zero)
        begin
            if (y_zero)
                vec_next.base = '0;
            else if (y_neg)
                vec_next.base = -at2d_pkg::QUARTER_TURN;
            else
                vec_next.base = at2d_pkg::QUARTER_TURN;
        end
        else if (y_zero)
        begin
            vec_next.base = x_neg ? at2d_pkg::HALF_TURN : '0;
        end
        else if (!x_neg)
        begin
            vec_next.rot = 1'b1;
        end
        else
        begin
            // turn by half a circle, measure, then add the offset back
            vec_next.rot  = 1'b1;
            vec_next.x    = -xs;
            vec_next.y    = -ys;
            vec_next.base = y_neg ? -at2d_pkg::HALF_TURN : at2d_pkg::HALF_TURN;
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            vec_reg <= vec_next;
    end

endmodule

[rtl/at2d_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at2d_cell
// one cordic vectoring micro-rotation with its own pipeline register
// ----------------------------------------------------------------------------
module at2d_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [at2d_pkg::STAGE_W-1:0]  stage,
    input  at2d_pkg::vec_t                in_vec,
    input  logic                          in_valid,
    output logic                          in_ready,
    output at2d_pkg::vec_t                out_vec,
    output logic                          out_valid,
    input  logic                          out_ready
);

    at2d_pkg::vec_t vec_reg;
    at2d_pkg::vec_t vec_next;
    logic           valid_reg;
    logic           valid_next;
    logic signed [at2d_pkg::X_W-1:0] x_in;
    logic signed [at2d_pkg::X_W-1:0] y_in;
    logic signed [at2d_pkg::X_W-1:0] dx;
    logic signed [at2d_pkg::X_W-1:0] dy;
    logic signed [at2d_pkg::Z_W-1:0] z_in;
    logic signed [at2d_pkg::Z_W-1:0] step_angle;

    assign in_ready  = !valid_reg || out_ready;
    assign out_vec   = vec_reg;
    assign out_valid = valid_reg;

    always_comb
    begin
        x_in       = in_vec.x;
        y_in       = in_vec.y;
        z_in       = in_vec.z;
        dx         = y_in >>> stage;
        dy         = x_in >>> stage;
        step_angle = at2d_pkg::atan_entry(stage);

        vec_next = in_vec;
        // rotate toward the x axis
        if (!y_in[at2d_pkg::X_W-1])
        begin
            vec_next.x = x_in + dx;
            vec_next.y = y_in - dy;
            vec_next.z = z_in + step_angle;
        end
        else
        begin
            vec_next.x = x_in - dx;
            vec_next.y = y_in + dy;
            vec_next.z = z_in - step_angle;
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            vec_reg <= vec_next;
    end

endmodule

[rtl/at2d_final.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at2d_final
// exit cell: rounds to 1/128 degree, adds the quadrant offset, saturates
// ----------------------------------------------------------------------------
module at2d_final (
    input  logic                              clk,
    input  logic                              rst_n,
    input  at2d_pkg::vec_t                    in_vec,
    input  logic                              in_valid,
    output logic                              in_ready,
    output logic signed [at2d_pkg::OUT_W-1:0] angle,
    output logic                              out_valid,
    input  logic                              out_ready
);

    logic signed [at2d_pkg::OUT_W-1:0] angle_reg;
    logic signed [at2d_pkg::OUT_W-1:0] angle_next;
    logic                              valid_reg;
    logic                              valid_next;
    logic signed [at2d_pkg::Z_W:0]     z_biased;
    logic signed [at2d_pkg::Z_W:0]     z_shifted;
    logic signed [at2d_pkg::R_W-1:0]   z_round;
    logic signed [at2d_pkg::A_W:0]     sum;
    logic signed [at2d_pkg::A_W:0]     lim_hi;
    logic signed [at2d_pkg::A_W:0]     lim_lo;

    assign in_ready  = !valid_reg || out_ready;
    assign angle     = angle_reg;
    assign out_valid = valid_reg;

    always_comb
    begin
        // round half up to 1/128 degree
        z_biased  = {in_vec.z[at2d_pkg::Z_W-1], in_vec.z} + at2d_pkg::RND_HALF;
        z_shifted = z_biased >>> at2d_pkg::RND_SHIFT;
        z_round   = z_shifted[at2d_pkg::R_W-1:0];

        sum = {in_vec.base[at2d_pkg::A_W-1], in_vec.base};
        if (in_vec.rot)
            sum = sum + (at2d_pkg::A_W + 1)'(z_round);

        lim_hi = (at2d_pkg::A_W + 1)'(at2d_pkg::HALF_TURN);
        lim_lo = -lim_hi;
        if (sum > lim_hi)
            sum = lim_hi;
        else if (sum < lim_lo)
            sum = lim_lo;
        angle_next = sum[at2d_pkg::OUT_W-1:0];

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            angle_reg <= angle_next;
    end

endmodule
